/* design/tnt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tnt_pkg: shared types and constants for the triangle normal/tangent block
// Vertex and result payloads, controller commands and state encoding.
// ----------------------------------------------------------------------------
package tnt_pkg;

	localparam int CoordW = 32;
	localparam int UnitW  = 16;
	localparam int UnitFracBits = 14;

	typedef struct packed {
		logic signed [CoordW-1:0] pos_x;
		logic signed [CoordW-1:0] pos_y;
		logic signed [CoordW-1:0] pos_z;
		logic signed [CoordW-1:0] tex_u;
		logic signed [CoordW-1:0] tex_v;
	} vertex_t;

	typedef struct packed {
		logic signed [UnitW-1:0] normal_x;
		logic signed [UnitW-1:0] normal_y;
		logic signed [UnitW-1:0] normal_z;
		logic signed [UnitW-1:0] tangent_x;
		logic signed [UnitW-1:0] tangent_y;
		logic signed [UnitW-1:0] tangent_z;
		logic                    flat_triangle;
		logic                    flat_mapping;
	} result_t;

	// Datapath operation selected by the controller each cycle
	typedef enum logic [3:0] {
		OP_NONE,
		OP_HOLD_A,
		OP_HOLD_B,
		OP_DIFF,
		OP_HALVE,
		OP_PROD,
		OP_SUM,
		OP_VEC,
		OP_SCALE,
		OP_SQ,
		OP_SQSUM,
		OP_SQRT,
		OP_DIV,
		OP_STORE
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic       sel_tan;  // 0: normal vector, 1: tangent vector
		logic [1:0] comp;     // component under division
	} dp_cmd_t;

	typedef struct packed {
		logic unit_busy;
		logic unit_done;
	} dp_status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_HALVE,
		ST_PROD,
		ST_SUM,
		ST_VEC,
		ST_SCALE,
		ST_SQ,
		ST_SQSUM,
		ST_SQRT,
		ST_DIV,
		ST_STORE,
		ST_OUT
	} state_t;

endpackage
`default_nettype wire

/* design/tnt_stream_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tnt_stream_if: valid/ready channel
// One transaction moves when valid and ready are both high at a clock edge.
// ----------------------------------------------------------------------------
interface tnt_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/triangle_normal_tangent.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_normal_tangent: unit face normal and tangent per triangle
// Three vertices in, one normal/tangent result out.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  vin      in   pos_x pos_y pos_z tex_u tex_v (signed Q16.16)
//  res      out  normal_xyz tangent_xyz (Q2.14), flat_triangle, flat_mapping
//
// The first and second corner are each stored as they are taken. After the
// third is taken, the result is offered once the shared sqrt/divider has
// done two square roots (31 steps each plus start and store) and six
// quotients (46 steps each plus issue and capture), plus twelve set-up steps.
// Reset clears the corner count and the result valid; no clearing pass.
// The result register waits for the sink; the first two corners of the
// next triangle are taken meanwhile.
module triangle_normal_tangent (
	input wire logic clk,
	input wire logic arst_n,
	tnt_stream_if.sink   vin,
	tnt_stream_if.source res
);
	import tnt_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;
	result_t    res_data;

	tnt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vin.valid),
		.in_ready (vin.ready),
		.out_valid(res.valid),
		.out_ready(res.ready),
		.status   (status),
		.cmd      (cmd)
	);

	tnt_datapath u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.vin   (vin.data),
		.cmd   (cmd),
		.status(status),
		.res   (res_data)
	);

	assign res.data = res_data;
endmodule
`default_nettype wire

/* design/tnt_divsqrt.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tnt_divsqrt: shared iterative square root and divider
// Square root of a 62-bit value, two radicand bits per cycle;
// unsigned division of a 46-bit numerator by a 31-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module tnt_divsqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start_sqrt,
	input  wire logic        start_div,
	input  wire logic [61:0] radicand,
	input  wire logic [45:0] numer,
	input  wire logic [30:0] denom,
	output logic             busy,
	output logic             done,
	output logic [45:0]      result
);
	import tnt_pkg::*;

	logic        run_q;
	logic        is_sqrt_q;
	logic [5:0]  cnt_q;
	logic [63:0] x_q;   // remaining radicand / dividend shift register
	logic [32:0] rem_q; // partial remainder
	logic [45:0] res_q;
	logic [30:0] den_q;

	logic [33:0] trial_sq;
	logic [34:0] rem_sq_ext;
	logic [31:0] trial_dv;
	logic [31:0] rem_dv_ext;

	// Sqrt: remainder gets two new bits, trial = 4r+1
	assign rem_sq_ext = {rem_q[32:0], x_q[63:62]};
	assign trial_sq   = {res_q[31:0], 2'b01};
	// Div: remainder gets one new bit
	assign rem_dv_ext = {rem_q[30:0], x_q[63]};
	assign trial_dv   = {1'b0, den_q};

	assign busy   = run_q;
	assign result = res_q;

	// Step the unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start_sqrt) begin
				run_q <= 1'b1;
				cnt_q <= 6'd31;
			end else if (start_div) begin
				run_q <= 1'b1;
				cnt_q <= 6'd46;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_sqrt) begin
			is_sqrt_q <= 1'b1;
			x_q       <= {radicand, 2'b00};
			rem_q     <= '0;
			res_q     <= '0;
		end else if (start_div) begin
			is_sqrt_q <= 1'b0;
			x_q       <= {numer, 18'd0};
			rem_q     <= '0;
			res_q     <= '0;
			den_q     <= denom;
		end else if (run_q) begin
			if (is_sqrt_q) begin
				x_q <= {x_q[61:0], 2'b00};
				if (rem_sq_ext >= {1'b0, trial_sq}) begin
					rem_q <= 33'(rem_sq_ext - {1'b0, trial_sq});
					res_q <= {res_q[44:0], 1'b1};
				end else begin
					rem_q <= rem_sq_ext[32:0];
					res_q <= {res_q[44:0], 1'b0};
				end
			end else begin
				x_q <= {x_q[62:0], 1'b0};
				if (rem_dv_ext >= trial_dv) begin
					rem_q <= {1'b0, rem_dv_ext - trial_dv};
					res_q <= {res_q[44:0], 1'b1};
				end else begin
					rem_q <= {1'b0, rem_dv_ext};
					res_q <= {res_q[44:0], 1'b0};
				end
			end
		end
	end
endmodule
`default_nettype wire

/* design/tnt_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tnt_datapath: corner store, differences, products and normalising
// Executes one controller command per cycle on held vertex data and the
// vectors under construction; owns the shared divider/sqrt unit.
// ----------------------------------------------------------------------------
module tnt_datapath (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire tnt_pkg::vertex_t vin,
	input  wire tnt_pkg::dp_cmd_t cmd,
	output tnt_pkg::dp_status_t   status,
	output tnt_pkg::result_t      res
);
	import tnt_pkg::*;

	logic signed [31:0] ha_q [5];  // corner a: x y z u v
	logic signed [31:0] hb_q [5];  // corner b
	logic signed [32:0] e_q  [6];
	logic signed [32:0] d_q  [4];
	logic signed [63:0] p_q  [12]; // partial products
	logic signed [63:0] n_q  [3];
	logic signed [63:0] t_q  [3];
	logic signed [63:0] det_q;
	logic        [63:0] m_q  [3];  // magnitudes of the selected vector
	logic        [61:0] sq_q [3];
	logic        [61:0] ssum_q;
	logic        [30:0] len_q;
	logic               nz_q;
	logic               neg_q [3];
	result_t            res_q;

	logic        [63:0] mc [3];
	logic        [63:0] top;
	logic        [5:0]  msb;
	logic               wide_e;
	logic               wide_d;
	logic               start_sqrt;
	logic               start_div;
	logic        [45:0] numer;
	logic        [14:0] q_sat;
	logic        [15:0] q_out;
	logic        [45:0] q_raw;
	logic               ds_busy;
	logic               ds_done;

	// Signed 32 x 32 product; halved differences fit in 32 bits
	function automatic logic signed [63:0] mul32(logic signed [32:0] a,
			logic signed [32:0] b);
		return 64'($signed(a[31:0]) * $signed(b[31:0]));
	endfunction

	assign res = res_q;
	assign status.unit_busy = ds_busy;
	assign status.unit_done = ds_done;

	// Magnitudes of the selected vector and their largest
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mc[i] = cmd.sel_tan ? ((t_q[i] < 0) ? 64'(-t_q[i]) : 64'(t_q[i]))
			                    : ((n_q[i] < 0) ? 64'(-n_q[i]) : 64'(n_q[i]));
		end
		top = m_q[0] | m_q[1] | m_q[2];
		msb = '0;
		for (int b = 0; b < 64; b++) begin
			if (top[b]) msb = 6'(b);
		end
		wide_e = 1'b0;
		for (int i = 0; i < 6; i++) begin
			if (e_q[i] >= 33'sh0_8000_0000 || e_q[i] <= -33'sh0_8000_0000) wide_e = 1'b1;
		end
		wide_d = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (d_q[i] >= 33'sh0_8000_0000 || d_q[i] <= -33'sh0_8000_0000) wide_d = 1'b1;
		end
	end

	assign start_sqrt = (cmd.op == OP_SQRT);
	assign start_div  = (cmd.op == OP_DIV);
	assign numer      = {m_q[cmd.comp][29:0], 14'd0} + 46'(len_q[30:1]);

	tnt_divsqrt u_divsqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.start_sqrt(start_sqrt),
		.start_div (start_div),
		.radicand  (ssum_q),
		.numer     (numer),
		.denom     (len_q),
		.busy      (ds_busy),
		.done      (ds_done),
		.result    (q_raw)
	);

	// Saturate the quotient to one and apply the sign
	always_comb begin
		q_sat = (q_raw > 46'd16384) ? 15'd16384 : q_raw[14:0];
		q_out = neg_q[cmd.comp] ? 16'(-{1'b0, q_sat}) : {1'b0, q_sat};
	end

	// Execute the command
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_HOLD_A: begin
				ha_q[0] <= vin.pos_x; ha_q[1] <= vin.pos_y; ha_q[2] <= vin.pos_z;
				ha_q[3] <= vin.tex_u; ha_q[4] <= vin.tex_v;
			end
			OP_HOLD_B: begin
				hb_q[0] <= vin.pos_x; hb_q[1] <= vin.pos_y; hb_q[2] <= vin.pos_z;
				hb_q[3] <= vin.tex_u; hb_q[4] <= vin.tex_v;
			end
			OP_DIFF: begin
				for (int i = 0; i < 3; i++) begin
					e_q[i]   <= 33'(hb_q[i]) - 33'(ha_q[i]);
				end
				e_q[3] <= 33'(vin.pos_x) - 33'(ha_q[0]);
				e_q[4] <= 33'(vin.pos_y) - 33'(ha_q[1]);
				e_q[5] <= 33'(vin.pos_z) - 33'(ha_q[2]);
				d_q[0] <= 33'(hb_q[3]) - 33'(ha_q[3]);
				d_q[1] <= 33'(hb_q[4]) - 33'(ha_q[4]);
				d_q[2] <= 33'(vin.tex_u) - 33'(ha_q[3]);
				d_q[3] <= 33'(vin.tex_v) - 33'(ha_q[4]);
			end
			OP_HALVE: begin
				if (wide_e) begin
					for (int i = 0; i < 6; i++) begin
						e_q[i] <= (e_q[i] < 0) ? -((-e_q[i]) >>> 1) : (e_q[i] >>> 1);
					end
				end
				if (wide_d) begin
					for (int i = 0; i < 4; i++) begin
						d_q[i] <= (d_q[i] < 0) ? -((-d_q[i]) >>> 1) : (d_q[i] >>> 1);
					end
				end
			end
			OP_PROD: begin
				p_q[0]  <= mul32(e_q[1], e_q[5]);
				p_q[1]  <= mul32(e_q[2], e_q[4]);
				p_q[2]  <= mul32(e_q[2], e_q[3]);
				p_q[3]  <= mul32(e_q[0], e_q[5]);
				p_q[4]  <= mul32(e_q[0], e_q[4]);
				p_q[5]  <= mul32(e_q[1], e_q[3]);
				p_q[6]  <= mul32(d_q[3], e_q[0]);
				p_q[7]  <= mul32(d_q[1], e_q[3]);
				p_q[8]  <= mul32(d_q[3], e_q[1]);
				p_q[9]  <= mul32(d_q[1], e_q[4]);
				p_q[10] <= mul32(d_q[3], e_q[2]);
				p_q[11] <= mul32(d_q[1], e_q[5]);
				det_q   <= mul32(d_q[0], d_q[3]);
				t_q[0]  <= mul32(d_q[2], d_q[1]);
			end
			OP_SUM: begin
				n_q[0] <= p_q[0] - p_q[1];
				n_q[1] <= p_q[2] - p_q[3];
				n_q[2] <= p_q[4] - p_q[5];
				det_q  <= det_q - t_q[0];
				t_q[0] <= p_q[6] - p_q[7];
				t_q[1] <= p_q[8] - p_q[9];
				t_q[2] <= p_q[10] - p_q[11];
			end
			OP_VEC: begin
				for (int i = 0; i < 3; i++) begin
					m_q[i]   <= mc[i];
					neg_q[i] <= cmd.sel_tan ? ((t_q[i] < 0) != (det_q < 0)) : (n_q[i] < 0);
				end
			end
			OP_SCALE: begin
				nz_q <= (top != 64'd0);
				for (int i = 0; i < 3; i++) begin
					if (msb >= 6'd29) m_q[i] <= m_q[i] >> (msb - 6'd29);
					else m_q[i] <= m_q[i] << (6'd29 - msb);
				end
			end
			OP_SQ: begin
				for (int i = 0; i < 3; i++) begin
					sq_q[i] <= 62'(m_q[i][29:0] * m_q[i][29:0]);
				end
			end
			OP_SQSUM: begin
				ssum_q <= sq_q[0] + sq_q[1] + sq_q[2];
			end
			OP_STORE: begin
				if (ds_done) len_q <= q_raw[30:0];
			end
			OP_DIV: begin
			end
			default: begin
			end
		endcase
		// Capture each finished quotient into the result
		if (ds_done && cmd.op == OP_NONE) begin
			if (!cmd.sel_tan) begin
				case (cmd.comp)
					2'd0: res_q.normal_x <= nz_q ? q_out : '0;
					2'd1: res_q.normal_y <= nz_q ? q_out : '0;
					default: res_q.normal_z <= nz_q ? q_out : '0;
				endcase
			end else begin
				case (cmd.comp)
					2'd0: res_q.tangent_x <= (nz_q && det_q != 0) ? q_out : '0;
					2'd1: res_q.tangent_y <= (nz_q && det_q != 0) ? q_out : '0;
					default: res_q.tangent_z <= (nz_q && det_q != 0) ? q_out : '0;
				endcase
			end
		end
		// Set the flags and clear a zero vector, or the tangent when the mapping is flat
		if (cmd.op == OP_SCALE) begin
			if (!cmd.sel_tan) begin
				res_q.flat_triangle <= (top == 64'd0);
				if (top == 64'd0) begin
					res_q.normal_x <= '0; res_q.normal_y <= '0; res_q.normal_z <= '0;
				end
			end else begin
				res_q.flat_mapping <= (det_q == 0);
				if (top == 64'd0 || det_q == 0) begin
					res_q.tangent_x <= '0; res_q.tangent_y <= '0; res_q.tangent_z <= '0;
				end
			end
		end
	end
endmodule
`default_nettype wire

/* design/tnt_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tnt_ctrl: triangle sequencer
// Counts corners, walks the datapath through both vectors and owns the
// input and output handshakes.
// ----------------------------------------------------------------------------
module tnt_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	input  wire tnt_pkg::dp_status_t status,
	output tnt_pkg::dp_cmd_t         cmd
);
	import tnt_pkg::*;

	state_t     state_q, state_d;
	logic [1:0] corner_q, corner_d;
	logic       tan_q, tan_d;
	logic [1:0] comp_q, comp_d;
	logic       wait_q, wait_d;   // division issued, awaiting quotient
	logic       ov_q, ov_d;

	assign out_valid = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			corner_q <= '0;
			tan_q    <= 1'b0;
			comp_q   <= '0;
			wait_q   <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			state_q  <= state_d;
			corner_q <= corner_d;
			tan_q    <= tan_d;
			comp_q   <= comp_d;
			wait_q   <= wait_d;
			ov_q     <= ov_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		corner_d = corner_q;
		tan_d    = tan_q;
		comp_d   = comp_q;
		wait_d   = wait_q;
		ov_d     = ov_q;
		in_ready = 1'b0;
		cmd.op      = OP_NONE;
		cmd.sel_tan = tan_q;
		cmd.comp    = comp_q;
		if (ov_q && out_ready) ov_d = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = (corner_q != 2'd2) || !ov_q;
				if (in_valid && in_ready) begin
					unique case (corner_q)
						2'd0: begin cmd.op = OP_HOLD_A; corner_d = 2'd1; end
						2'd1: begin cmd.op = OP_HOLD_B; corner_d = 2'd2; end
						default: begin
							cmd.op = OP_DIFF; corner_d = 2'd0; state_d = ST_HALVE;
						end
					endcase
				end
			end
			ST_HALVE: begin cmd.op = OP_HALVE; state_d = ST_PROD; end
			ST_PROD:  begin cmd.op = OP_PROD;  state_d = ST_SUM; end
			ST_SUM:   begin cmd.op = OP_SUM; tan_d = 1'b0; state_d = ST_VEC; end
			ST_VEC:   begin cmd.op = OP_VEC;   state_d = ST_SCALE; end
			ST_SCALE: begin cmd.op = OP_SCALE; state_d = ST_SQ; end
			ST_SQ:    begin cmd.op = OP_SQ;    state_d = ST_SQSUM; end
			ST_SQSUM: begin cmd.op = OP_SQSUM; state_d = ST_SQRT; end
			ST_SQRT: begin
				cmd.op = OP_SQRT; state_d = ST_STORE;
			end
			ST_STORE: begin
				if (status.unit_done) begin
					cmd.op = OP_STORE; comp_d = 2'd0; wait_d = 1'b0; state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (!wait_q) begin
					cmd.op = OP_DIV; wait_d = 1'b1;
				end else if (status.unit_done) begin
					wait_d = 1'b0;
					if (comp_q == 2'd2) begin
						if (!tan_q) begin
							tan_d = 1'b1; state_d = ST_VEC;
						end else begin
							state_d = ST_OUT;
						end
					end else begin
						comp_d = comp_q + 2'd1;
					end
				end
			end
			ST_OUT: begin
				if (!ov_q) begin
					ov_d = 1'b1; state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

/* design/tnt_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tnt_checker: port-level checks for the normal/tangent block
// Watches the result handshake and the flat-triangle flag on the top-level ports.
// ----------------------------------------------------------------------------
module tnt_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic flat_triangle,
	input wire logic [15:0] normal_x
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(normal_x)) else $error("result changed");
	a_flat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && flat_triangle |-> normal_x == 16'd0) else $error("flat normal");
	a_no_back: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid) else $error("repeated result");
endmodule

bind triangle_normal_tangent tnt_checker u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (vin.valid),
	.in_ready     (vin.ready),
	.out_valid    (res.valid),
	.out_ready    (res.ready),
	.flat_triangle(res.data.flat_triangle),
	.normal_x     (res.data.normal_x)
);
`default_nettype wire
